// ----- rtl/mbm_pkg.sv -----
// Package: shared types and constants for the multicart bank mapper.
package mbm_pkg;

  localparam int AddrW = 29;

  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_PPU   = 3'd2,
    MODE_TICK  = 3'd3,
    MODE_RESET = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_PRG   = 3'd1,
    TGT_WRAM  = 3'd2,
    TGT_CHR   = 3'd3,
    TGT_CHRAM = 3'd4,
    TGT_NT    = 3'd5
  } target_t;

  localparam logic [2:0] CFG_VARIANT = 3'd0;
  localparam logic [2:0] CFG_CHR2K   = 3'd1;
  localparam logic [2:0] CFG_FIXMIR  = 3'd2;
  localparam logic [2:0] CFG_WINSEL  = 3'd3;
  localparam logic [2:0] CFG_MIXCHR  = 3'd4;
  localparam logic [2:0] CFG_WRAMP   = 3'd5;

  typedef struct packed {
    logic [2:0] variant;
    logic       chr_2k;
    logic       fix_mir;
    logic [2:0] win_sel;
    logic       mix_chr;
    logic       wram_p;
  } cfg_t;

  // Mapper register state, visible to the translation logic.
  typedef struct packed {
    logic [7:0] latch;
    logic [7:0] high_outer;
    logic [7:0][7:0] outer;
    logic [15:0][7:0] inner;
    logic [7:0] bank_sel;
    logic [7:0] mirror;
    logic [7:0] wram_ctl;
  } regs_t;

  function automatic logic [2:0] eff_variant(input logic [2:0] v);
    return (v > 3'd5) ? 3'd0 : v;
  endfunction

  function automatic logic [7:0] prg_mask(input logic [2:0] m);
    case (m)
      3'd0: prg_mask = 8'h3F;
      3'd1: prg_mask = 8'h1F;
      3'd2: prg_mask = 8'h0F;
      3'd6: prg_mask = 8'h7F;
      3'd7: prg_mask = 8'hFF;
      default: prg_mask = 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] ext_idx(input logic [2:0] i);
    case (i)
      3'd0: ext_idx = 4'd0;
      3'd1: ext_idx = 4'd10;
      3'd2: ext_idx = 4'd1;
      3'd3: ext_idx = 4'd11;
      3'd4: ext_idx = 4'd2;
      3'd5: ext_idx = 4'd3;
      3'd6: ext_idx = 4'd4;
      default: ext_idx = 4'd5;
    endcase
  endfunction

endpackage

// ----- rtl/mbm_if.sv -----
// Interfaces: valid/ready channels for input, result and configuration.
interface mbm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, mode, address, write_data, input ready);
  modport sink (input valid, mode, address, write_data, output ready);
endinterface

interface mbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [28:0] mapped_address;
  logic        irq_line;
  modport source (output valid, target, mapped_address, irq_line, input ready);
  modport sink (input valid, target, mapped_address, irq_line, output ready);
endinterface

interface mbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mbm_xlate.sv -----
// Address translation: maps one bus access to a target memory and flat address.
module mbm_xlate import mbm_pkg::*; (
  input  cfg_t         cfg,
  input  regs_t        regs,
  input  logic [2:0]   mode,
  input  logic [15:0]  address,
  output logic [2:0]   target,
  output logic [28:0]  mapped
);

  logic [2:0]  v;
  logic        iext, wext, oen;
  logic        wram_ok;
  logic [28:0] wram_addr;
  logic [28:0] prg_a;
  logic [2:0]  chr_t;
  logic [28:0] chr_a;
  logic        win_hit;

  assign v    = eff_variant(cfg.variant);
  assign iext = regs.outer[3][1];
  assign wext = regs.wram_ctl[5] && (v == 3'd2);
  assign oen  = regs.wram_ctl[6] || !wext;
  assign win_hit = |(address & (16'h0010 << cfg.win_sel));

  // work RAM window
  always_comb begin
    logic [1:0] wb;
    wram_ok   = 1'b0;
    wram_addr = '0;
    wb = (address < 16'h6000) ? (regs.wram_ctl[1:0] + 2'd1) : regs.wram_ctl[1:0];
    if (cfg.wram_p && regs.wram_ctl[7]) begin
      if (v == 3'd2) begin
        wram_ok   = 1'b1;
        wram_addr = {14'd0, wb, address[12:0]};
      end else if (address >= 16'h6000) begin
        wram_ok   = 1'b1;
        wram_addr = {16'd0, address[12:0]};
      end
    end
  end

  // PRG
  always_comb begin
    logic [7:0]  mask, val;
    logic [14:0] base;
    logic [1:0]  slot;
    logic [2:0]  m;
    logic [15:0] bank, base2;
    logic [14:0] b16;
    m    = regs.outer[0][2:0];
    mask = prg_mask(m);
    slot = address[14:13];
    if ((v == 3'd1 || v == 3'd3) && (m == 3'd0 || iext)) mask = 8'hFF;
    base = {8'd0, regs.outer[1][6:0]};
    case (v)
      3'd2: base = base | {3'd0, regs.outer[2][5], regs.outer[2][7:6],
                          regs.outer[0][7], regs.outer[0][3], 7'd0};
      3'd3: base = base | {regs.outer[5], 7'd0};
      3'd4: base = base | {7'd0, regs.outer[2][7], 7'd0};
      3'd5: base = {2'd0, regs.high_outer, regs.outer[1][4:0]};
      default: ;
    endcase
    val = 8'h00;
    b16 = '0;
    base2 = '0;
    if (m == 3'd3) begin
      bank = {base, slot[0]};
    end else if (m == 3'd4) begin
      bank = {base[14:1], slot};
    end else if (m == 3'd5) begin
      b16  = {base[14:3], (slot[1] ? 3'd7 : regs.latch[2:0])};
      bank = {b16, slot[0]};
    end else begin
      if (regs.bank_sel[6] && !slot[0]) slot = slot ^ 2'd2;
      case (slot)
        2'd0: val = regs.inner[6];
        2'd1: val = regs.inner[7];
        2'd2: val = iext ? regs.inner[8] : 8'hFE;
        default: val = iext ? regs.inner[9] : 8'hFF;
      endcase
      base2 = {base, 1'b0};
      bank  = (base2 & ~{8'd0, mask}) | {8'd0, val & mask};
    end
    prg_a = {bank, address[12:0]};
  end

  // CHR and nametable
  always_comb begin
    logic [2:0]  s;
    logic [18:0] base, mask, val, b;
    logic        big, cn, inv, ram;
    logic [13:0] pa;
    logic [1:0]  mir;
    pa  = address[13:0];
    inv = regs.bank_sel[7];
    mir = 2'd0;
    if (cfg.chr_2k) s = {(pa[12:11] ^ {inv, 1'b0}), 1'b0};
    else s = pa[12:10] ^ {inv, 2'b00};
    big  = regs.outer[0][4];
    base = {8'd0, regs.outer[2], 3'd0};
    if (v == 3'd3) base = base | {regs.outer[6], 11'd0};
    mask = big ? 19'h7F : 19'hFF;
    val  = '0;
    cn   = 1'b0;
    if (regs.outer[0][6]) begin
      cn   = !regs.outer[0][5] && (v == 3'd1 || v == 3'd5);
      mask = cn ? (big ? 19'd1 : 19'd3) : 19'd0;
      if (v != 3'd5) base = base & ~(mask << 3);
      base = base | (({11'd0, regs.latch} & mask) << 3);
      b = base | {16'd0, s};
    end else begin
      if (iext) val = {11'd0, regs.inner[ext_idx(s)]};
      else if (!s[2]) begin
        val = {11'd0, regs.inner[{3'd0, s[1]}]};
        val[0] = s[0];
      end else val = {11'd0, regs.inner[{2'd0, s[1:0]} + 4'd2]};
      b = (base & ~mask) | (val & mask);
    end
    ram = 1'b0;
    if (cfg.mix_chr) begin
      if (regs.outer[0][5] && (v == 3'd0 || v == 3'd1)) ram = 1'b1;
      else if (wext && regs.wram_ctl[2] && b < 19'd8) ram = 1'b1;
    end
    chr_t = TGT_NONE;
    chr_a = '0;
    if (!pa[13]) begin
      if (cfg.chr_2k) begin
        chr_t = TGT_CHR;
        chr_a = {b[17:0], pa[10:0]};
      end else begin
        chr_t = ram ? TGT_CHRAM : TGT_CHR;
        chr_a = {b, pa[9:0]};
      end
    end else if (pa < 14'h3F00) begin
      if (cfg.chr_2k) mir = cfg.fix_mir ? 2'd0 : 2'd1;
      else mir = regs.mirror[1:0] & ((v == 3'd2) ? 2'd3 : 2'd1);
      chr_t = TGT_NT;
      case (mir)
        2'd0: chr_a = {18'd0, pa[10], pa[9:0]};
        2'd1: chr_a = {18'd0, pa[11], pa[9:0]};
        2'd2: chr_a = {18'd0, 1'b0, pa[9:0]};
        default: chr_a = {18'd0, 1'b1, pa[9:0]};
      endcase
    end
  end

  always_comb begin
    target = TGT_NONE;
    mapped = '0;
    case (mode)
      MODE_WRITE: begin
        if (address < 16'h8000 && address >= 16'h6000) begin
          if (wram_ok) target = TGT_WRAM;
        end else if (address < 16'h6000 && address >= 16'h5000) begin
          if (!(oen && win_hit) && wram_ok) target = TGT_WRAM;
        end
        mapped = wram_addr;
      end
      MODE_READ: begin
        if (address >= 16'h8000) begin
          target = TGT_PRG;
          mapped = prg_a;
        end else if (address >= 16'h6000 || (address >= 16'h5000 && v == 3'd2)) begin
          if (wram_ok) target = TGT_WRAM;
          mapped = wram_addr;
        end
      end
      MODE_PPU: begin
        target = chr_t;
        mapped = chr_a;
      end
      default: ;
    endcase
    if (target == TGT_NONE) mapped = '0;
  end

endmodule

// ----- rtl/mbm_state.sv -----
// Register file and scanline counter: applies writes, ticks and soft resets.
module mbm_state import mbm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         step,
  input  logic [2:0]   mode,
  input  logic [15:0]  address,
  input  logic [7:0]   write_data,
  output regs_t        regs,
  output logic         irq_nxt_o
);

  regs_t      regs_r, regs_nxt, regs_init;
  logic [7:0] cnt_r, cnt_nxt, reload_r, reload_nxt;
  logic       en_r, en_nxt, req_r, req_nxt, pend_r, pend_nxt;
  logic [2:0] v;

  assign v    = eff_variant(cfg.variant);
  assign regs = regs_r;

  always_comb begin
    regs_init = '0;
    regs_init.inner[0] = 8'h00; regs_init.inner[1] = 8'h02;
    regs_init.inner[2] = 8'h04; regs_init.inner[3] = 8'h05;
    regs_init.inner[4] = 8'h06; regs_init.inner[5] = 8'h07;
    regs_init.inner[6] = 8'h00; regs_init.inner[7] = 8'h01;
    regs_init.inner[8] = 8'hFE; regs_init.inner[9] = 8'hFF;
    regs_init.inner[10] = 8'hFF; regs_init.inner[11] = 8'hFF;
    regs_init.wram_ctl = (v == 3'd2) ? 8'hC0 : 8'h80;
    if (v == 3'd1) regs_init.outer[1] = 8'hFF;
  end

  always_comb begin
    logic [7:0] d;
    logic       wext, oen;
    logic [7:0] cdec;
    regs_nxt   = regs_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    en_nxt     = en_r;
    req_nxt    = req_r;
    pend_nxt   = pend_r;
    d    = write_data;
    wext = regs_r.wram_ctl[5] && (v == 3'd2);
    oen  = regs_r.wram_ctl[6] || !wext;
    cdec = (cnt_r == 8'd0 || req_r) ? reload_r : cnt_r - 8'd1;
    if (step) begin
      case (mode)
        MODE_WRITE: begin
          if (address[15]) begin
            regs_nxt.latch = d;
            case (address[14:13])
              2'd0: begin
                if (!address[1]) begin
                  if (address[0]) begin
                    regs_nxt.inner[regs_r.bank_sel[3:0] &
                                   (regs_r.outer[3][1] ? 4'hF : 4'h7)] = d;
                  end else begin
                    if (v == 3'd2 && (d == 8'h46 || d == 8'h47)) d = d ^ 8'h01;
                    regs_nxt.bank_sel = d;
                  end
                end
              end
              2'd1: begin
                if (address[0]) begin
                  if (!d[5]) d = d & 8'hC0;
                  regs_nxt.wram_ctl = d;
                end else regs_nxt.mirror = d;
              end
              2'd2: begin
                if (address[0]) req_nxt = 1'b1;
                else reload_nxt = d;
              end
              default: begin
                if (address[0]) en_nxt = 1'b1;
                else begin
                  en_nxt   = 1'b0;
                  pend_nxt = 1'b0;
                end
              end
            endcase
          end else if (address >= 16'h5000 && address < 16'h6000) begin
            if (oen && |(address & (16'h0010 << cfg.win_sel)))
              regs_nxt.outer[{address[2] & (v == 3'd3), address[1:0]}] = d;
          end else if (address >= 16'h4800 && address < 16'h5000 && v == 3'd5) begin
            regs_nxt.high_outer = d;
          end
        end
        MODE_TICK: begin
          cnt_nxt = cdec;
          if (cdec == 8'd0 && en_r) pend_nxt = 1'b1;
          req_nxt = 1'b0;
        end
        MODE_RESET: begin
          regs_nxt   = regs_init;
          cnt_nxt    = '0;
          reload_nxt = '0;
          en_nxt     = 1'b0;
          req_nxt    = 1'b0;
          pend_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign irq_nxt_o = pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r   <= regs_init;
      cnt_r    <= '0;
      reload_r <= '0;
      en_r     <= 1'b0;
      req_r    <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      regs_r   <= regs_nxt;
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      en_r     <= en_nxt;
      req_r    <= req_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ----- rtl/multicart_bank_mapper_with_scanline_irq.sv -----
// Top level: multicart bank mapper with scanline interrupt.
//   channel | dir | payload
//   in_     | in  | mode, address, write_data
//   out_    | out | target, mapped_address, irq_line
//   cfg_    | in  | index, data
// One transaction per cycle unless the output stalls; translation and state
// update take effect in the accept cycle, which loads the output register.
// Input ready follows output space: it stays high while the result register is
// empty or being drained. Synchronous active-low reset loads the power-on state.
module multicart_bank_mapper_with_scanline_irq import mbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mbm_in_if.sink     in_ch,
  mbm_out_if.source  out_ch,
  mbm_cfg_if.sink    cfg_ch
);

  cfg_t        cfg_r, cfg_nxt;
  regs_t       regs;
  logic        step, irq_nxt;
  logic [2:0]  tgt;
  logic [28:0] ma;
  logic        ov_r;
  logic [2:0]  tgt_r;
  logic [28:0] ma_r;
  logic        irq_r;

  assign in_ch.ready  = !ov_r || out_ch.ready;
  assign step         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_VARIANT: cfg_nxt.variant = cfg_ch.data[2:0];
        CFG_CHR2K:   cfg_nxt.chr_2k  = cfg_ch.data[0];
        CFG_FIXMIR:  cfg_nxt.fix_mir = cfg_ch.data[0];
        CFG_WINSEL:  cfg_nxt.win_sel = cfg_ch.data[2:0];
        CFG_MIXCHR:  cfg_nxt.mix_chr = cfg_ch.data[0];
        CFG_WRAMP:   cfg_nxt.wram_p  = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '{variant: 3'd0, chr_2k: 1'b0, fix_mir: 1'b0,
                           win_sel: 3'd0, mix_chr: 1'b0, wram_p: 1'b1};
    else cfg_r <= cfg_nxt;
  end

  mbm_state u_state (
    .clk, .rst_n, .cfg(cfg_r), .step,
    .mode(in_ch.mode), .address(in_ch.address), .write_data(in_ch.write_data),
    .regs, .irq_nxt_o(irq_nxt)
  );

  mbm_xlate u_xlate (
    .cfg(cfg_r), .regs, .mode(in_ch.mode), .address(in_ch.address),
    .target(tgt), .mapped(ma)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tgt_r <= tgt;
      ma_r  <= ma;
      irq_r <= irq_nxt;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.target         = tgt_r;
  assign out_ch.mapped_address = ma_r;
  assign out_ch.irq_line       = irq_r;

endmodule

// ----- bench/mbm_tb_pkg.sv -----
// Scoreboard class: mapper translation predictor and expected-result store.
package mbm_tb_pkg;
  import mbm_pkg::*;

  typedef struct packed {
    logic [2:0]  target;
    logic [28:0] maddr;
    logic        irq;
  } mapped_t;

  class mapper_scoreboard;
    // configuration
    logic [2:0] variant_cfg, win_sel;
    logic       chr2k, fixmir, mixchr, wramp;
    // mapper state
    logic [7:0] latch, high_outer, bank_sel, mirror, wram_ctl;
    logic [7:0] outer[8];
    logic [7:0] inner[16];
    logic [7:0] counter, reload_val;
    logic       irq_en, reload_req, irq_pend;
    mapped_t    pending_q[$];
    int         errors;

    function new();
      errors = 0;
      variant_cfg = 0; chr2k = 0; fixmir = 0; win_sel = 0; mixchr = 0; wramp = 1;
      power_on();
    endfunction

    function int vnt();
      return (variant_cfg > 3'd5) ? 0 : variant_cfg;
    endfunction

    function bit inner_ext();
      return outer[3][1];
    endfunction

    function bit wram_ext();
      return wram_ctl[5] && vnt() == 2;
    endfunction

    function void power_on();
      logic [7:0] init[16] = '{8'h00, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h00, 8'h01,
                               8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
      latch = 0; high_outer = 0; bank_sel = 0; mirror = 0;
      foreach (outer[i]) outer[i] = 0;
      foreach (inner[i]) inner[i] = init[i];
      wram_ctl = (vnt() == 2) ? 8'hC0 : 8'h80;
      if (vnt() == 1) outer[1] = 8'hFF;
      counter = 0; reload_val = 0; irq_en = 0; reload_req = 0; irq_pend = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] d);
      case (idx)
        CFG_VARIANT: variant_cfg = d[2:0];
        CFG_CHR2K:   chr2k = d[0];
        CFG_FIXMIR:  fixmir = d[0];
        CFG_WINSEL:  win_sel = d[2:0];
        CFG_MIXCHR:  mixchr = d[0];
        CFG_WRAMP:   wramp = d[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] prg_translate(logic [15:0] a);
      int v;
      logic [2:0] m;
      logic [31:0] mask, base, slot, bank, val, b16;
      v = vnt(); m = outer[0][2:0];
      case (m)
        0: mask = 'h3F; 1: mask = 'h1F; 2: mask = 'h0F;
        6: mask = 'h7F; 7: mask = 'hFF; default: mask = 0;
      endcase
      base = outer[1] & 'h7F;
      slot = (a >> 13) & 3;
      if ((v == 1 || v == 3) && (m == 0 || inner_ext())) mask = 'hFF;
      if (v == 2)
        base |= ((32'(outer[0]) << 4) & 'h80) | ((32'(outer[0]) << 1) & 'h100) |
                ((32'(outer[2]) << 3) & 'h600) | ((32'(outer[2]) << 6) & 'h800);
      else if (v == 3) base |= 32'(outer[5]) << 7;
      else if (v == 4) base |= outer[2] & 'h80;
      else if (v == 5) base = (base & 'h1F) | (32'(high_outer) << 5);
      if (m == 3) bank = (base << 1) | (slot & 1);
      else if (m == 4) bank = ((base >> 1) << 2) | slot;
      else if (m == 5) begin
        b16 = (base & ~32'd7) | (slot[1] ? 7 : (latch & 7));
        bank = (b16 << 1) | (slot & 1);
      end else begin
        if (bank_sel[6] && !slot[0]) slot ^= 2;
        case (slot)
          0: val = inner[6];
          1: val = inner[7];
          2: val = inner_ext() ? inner[8] : 'hFE;
          default: val = inner_ext() ? inner[9] : 'hFF;
        endcase
        base <<= 1;
        bank = (base & ~mask) | (val & mask);
      end
      return ((bank << 13) | (a & 'h1FFF)) & 'h1FFFFFFF;
    endfunction

    function logic [31:0] chr_select(int i);
      int v;
      logic [31:0] base, mask, val;
      bit big, cn;
      int xi[8] = '{0, 10, 1, 11, 2, 3, 4, 5};
      v = vnt();
      base = 32'(outer[2]) << 3;
      big = outer[0][4];
      mask = big ? 'h7F : 'hFF;
      if (v == 3) base |= 32'(outer[6]) << 11;
      if (outer[0][6]) begin
        cn = !outer[0][5] && (v == 1 || v == 5);
        mask = cn ? (big ? 1 : 3) : 0;
        if (v != 5) base &= ~(mask << 3);
        base |= (latch & mask) << 3;
        return base | i;
      end
      if (inner_ext()) val = inner[xi[i & 7]];
      else if (i < 4) begin
        val = inner[i >> 1];
        val = (i & 1) ? (val | 1) : (val & 'hFE);
      end else val = inner[i - 2];
      return (base & ~mask) | (val & mask);
    endfunction

    function bit wram_window(logic [15:0] a, output logic [31:0] ma);
      logic [31:0] bank;
      ma = 0;
      if (!wramp || !wram_ctl[7]) return 0;
      if (vnt() == 2) begin
        bank = (a < 'h6000) ? ((wram_ctl + 1) & 3) : (wram_ctl & 3);
        ma = (bank << 13) | (a & 'h1FFF);
        return 1;
      end
      if (a < 'h6000) return 0;
      ma = a & 'h1FFF;
      return 1;
    endfunction

    function void ppu_translate(logic [15:0] a_in, output logic [2:0] t,
                                output logic [31:0] ma);
      logic [31:0] a, q, s, b;
      bit inv, ram;
      int mir;
      a = a_in & 'h3FFF; t = TGT_NONE; ma = 0;
      inv = bank_sel[7];
      if (a < 'h2000) begin
        if (chr2k) begin
          q = ((a >> 11) & 3) ^ (inv << 1);
          t = TGT_CHR;
          ma = ((chr_select(q * 2) << 11) | (a & 'h7FF)) & 'h1FFFFFFF;
        end else begin
          s = ((a >> 10) & 7) ^ (inv << 2);
          b = chr_select(s);
          ram = 0;
          if (mixchr) begin
            if (outer[0][5] && (vnt() == 0 || vnt() == 1)) ram = 1;
            else if (wram_ext() && wram_ctl[2] && b < 8) ram = 1;
          end
          t = ram ? TGT_CHRAM : TGT_CHR;
          ma = ((b << 10) | (a & 'h3FF)) & 'h1FFFFFFF;
        end
      end else if (a < 'h3F00) begin
        if (chr2k) mir = fixmir ? 0 : 1;
        else mir = mirror & (vnt() == 2 ? 3 : 1);
        t = TGT_NT;
        case (mir)
          0: ma = (a & 'h3FF) | (a & 'h400);
          1: ma = (a & 'h3FF) | ((a >> 1) & 'h400);
          2: ma = a & 'h3FF;
          default: ma = (a & 'h3FF) | 'h400;
        endcase
      end
    endfunction

    function void mapper_write(logic [15:0] a, logic [7:0] d);
      latch = d;
      case (a[14:13])
        0: if (!a[1]) begin
          if (a[0]) inner[bank_sel & (inner_ext() ? 8'h0F : 8'h07)] = d;
          else begin
            if (vnt() == 2 && (d == 8'h46 || d == 8'h47)) d ^= 1;
            bank_sel = d;
          end
        end
        1: if (a[0]) begin
          if (!d[5]) d &= 8'hC0;
          wram_ctl = d;
        end else mirror = d;
        2: if (a[0]) reload_req = 1; else reload_val = d;
        default: if (a[0]) irq_en = 1; else begin irq_en = 0; irq_pend = 0; end
      endcase
    endfunction

    // Step the predictor on one accepted input transaction.
    function void note_input(logic [2:0] mode, logic [15:0] a, logic [7:0] d);
      logic [2:0] t;
      logic [31:0] ma;
      mapped_t r;
      t = TGT_NONE; ma = 0;
      case (mode)
        MODE_WRITE: begin
          if (a >= 'h8000) mapper_write(a, d);
          else if (a >= 'h6000) begin
            if (wram_window(a, ma)) t = TGT_WRAM;
          end else if (a >= 'h5000) begin
            if ((wram_ctl[6] || !wram_ext()) && (a & (16'h10 << win_sel)) != 0)
              outer[a & (vnt() == 3 ? 7 : 3)] = d;
            else if (wram_window(a, ma)) t = TGT_WRAM;
          end else if (a >= 'h4800 && vnt() == 5) high_outer = d;
        end
        MODE_READ: begin
          if (a >= 'h8000) begin
            t = TGT_PRG; ma = prg_translate(a);
          end else if (a >= 'h6000 || (a >= 'h5000 && vnt() == 2)) begin
            if (wram_window(a, ma)) t = TGT_WRAM;
          end
        end
        MODE_PPU: ppu_translate(a, t, ma);
        MODE_TICK: begin
          if (counter == 0 || reload_req) counter = reload_val;
          else counter--;
          if (counter == 0 && irq_en) irq_pend = 1;
          reload_req = 0;
        end
        MODE_RESET: power_on();
        default: ;
      endcase
      if (t == TGT_NONE) ma = 0;
      r.target = t; r.maddr = ma[28:0]; r.irq = irq_pend;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] t, logic [28:0] ma, logic irq);
      mapped_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: target %0d addr %h", t, ma);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (t !== e.target) begin
        $error("target: expected %0d, got %0d", e.target, t); errors++;
      end
      if (ma !== e.maddr) begin
        $error("mapped_address: expected %h, got %h", e.maddr, ma); errors++;
      end
      if (irq !== e.irq) begin
        $error("irq_line: expected %0d, got %0d", e.irq, irq); errors++;
      end
    endfunction
  endclass
endpackage

// ----- bench/testbench.sv -----
// Top-level testbench: drives the mapper and checks every translated access.
module testbench;
  import mbm_pkg::*;
  import mbm_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;

  logic clk, rst_n;
  mbm_in_if in_ch();
  mbm_out_if out_ch();
  mbm_cfg_if cfg_ch();

  mapper_scoreboard sb = new();
  int idle_cycles;

  multicart_bank_mapper_with_scanline_irq uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Check results and sample handshakes at the edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.target, out_ch.mapped_address, out_ch.irq_line);
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.mode, in_ch.address, in_ch.write_data);
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Result-side stalls.
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    forever begin
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      repeat (g) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("** multicart_bank_mapper_with_scanline_irq: FAILED **");
    $finish;
  end

  task automatic send_access(logic [2:0] mode, logic [15:0] a, logic [7:0] d, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.address <= a;
    in_ch.write_data <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    end_burst();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic set_board(logic [2:0] v, bit c2k, bit fm, logic [2:0] ws, bit mx, bit wp);
    write_reg(CFG_VARIANT, {5'd0, v});
    write_reg(CFG_CHR2K, {7'd0, c2k});
    write_reg(CFG_FIXMIR, {7'd0, fm});
    write_reg(CFG_WINSEL, {5'd0, ws});
    write_reg(CFG_MIXCHR, {7'd0, mx});
    write_reg(CFG_WRAMP, {7'd0, wp});
  endtask

  // Random bus event, weighted toward register writes and translated accesses.
  task automatic random_access(int ws);
    int r;
    logic [15:0] a;
    logic [7:0] d;
    logic [2:0] mode;
    r = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    a = 16'($urandom_range(0, 65535));
    if (r < 12) begin
      mode = MODE_WRITE;
      a = 16'h5000 | (16'h10 << ws) | 16'($urandom_range(0, 'hFFF));
    end else if (r < 32) begin
      mode = MODE_WRITE; a = 16'h8000 | a[14:0];
      if ($urandom_range(0, 1)) d = $urandom_range(0, 3) == 0 ? 8'h46 : d & 8'hCF;
    end else if (r < 38) mode = MODE_WRITE;
    else if (r < 58) begin
      mode = MODE_READ;
      if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
    end else if (r < 80) mode = MODE_PPU;
    else if (r < 95) mode = MODE_TICK;
    else if (r < 97) mode = MODE_RESET;
    else mode = 3'($urandom_range(5, 7));
    send_access(mode, a, d, 1'b1);
  endtask

  initial begin
    logic [2:0] v;
    int ws;
    rst_n = 1'b0;
    idle_cycles = 0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_TICK;
    in_ch.address <= '0;
    in_ch.write_data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_VARIANT;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every mode, IRQ path, banking specials.
    send_access(MODE_READ, 16'hFFFF, 8'h00, 0);
    send_access(MODE_READ, 16'h8000, 8'h00, 0);
    send_access(MODE_READ, 16'h0000, 8'hFF, 0);
    send_access(MODE_READ, 16'h6000, 8'h00, 0);
    send_access(MODE_WRITE, 16'h7FFF, 8'hFF, 0);
    send_access(MODE_PPU, 16'h0000, 8'h00, 0);
    send_access(MODE_PPU, 16'hFFFF, 8'h00, 0);
    send_access(MODE_PPU, 16'h3F00, 8'h00, 0);
    send_access(MODE_PPU, 16'h2C00, 8'h00, 0);
    send_access(MODE_WRITE, 16'hC000, 8'h02, 0);
    send_access(MODE_WRITE, 16'hE001, 8'h00, 0);
    send_access(MODE_WRITE, 16'hC001, 8'h00, 0);
    send_access(MODE_TICK, 16'h0000, 8'h00, 0);
    send_access(MODE_TICK, 16'h0000, 8'h00, 0);
    send_access(MODE_TICK, 16'h0000, 8'h00, 0);
    send_access(MODE_WRITE, 16'hE000, 8'h00, 0);
    send_access(MODE_WRITE, 16'h5010, 8'h45, 0);
    send_access(MODE_WRITE, 16'h5013, 8'h12, 0);
    send_access(MODE_WRITE, 16'hA001, 8'h24, 0);
    send_access(MODE_WRITE, 16'h8000, 8'hC6, 0);
    send_access(MODE_READ, 16'hC123, 8'h00, 0);
    send_access(MODE_PPU, 16'h1BFF, 8'h00, 0);
    send_access(3'd7, 16'h1234, 8'h55, 0);
    send_access(MODE_RESET, 16'h0000, 8'h00, 0);
    wait_drained();

    // Phases over board settings, extremes first.
    for (int ph = 0; ph < 12; ph++) begin
      v = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      ws = (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7);
      set_board(v, ph == 3 || ph == 9, ph[0], 3'(ws), ph != 0 && ph != 4, ph != 5);
      send_access(MODE_RESET, 16'h0000, 8'h00, 0);
      for (int k = 0; k < 136; k++) begin
        random_access(ws);
        // Hold off once until the mapper has drained everything.
        if (ph == 6 && k == 60) begin
          end_burst();
          while (sb.pending_q.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("** multicart_bank_mapper_with_scanline_irq: PASSED **");
    else begin
      if (sb.pending_q.size() != 0) $error("%0d results never arrived", sb.pending_q.size());
      $display("** multicart_bank_mapper_with_scanline_irq: FAILED **");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/mbm_pkg.sv
rtl/mbm_if.sv
rtl/mbm_xlate.sv
rtl/mbm_state.sv
rtl/multicart_bank_mapper_with_scanline_irq.sv
bench/mbm_tb_pkg.sv
bench/testbench.sv
